[sv/email_address_validator_core_assert.svh]
// assertion macros shared by the mailbox checker modules
// expects clk and arst_n in the scope of each use
`ifndef EMAIL_ADDRESS_VALIDATOR_CORE_ASSERT_SVH
`define EMAIL_ADDRESS_VALIDATOR_CORE_ASSERT_SVH

// property that holds at every edge out of reset
`define EAVC_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define EAVC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EAVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/eavc_pkg.sv]
// types and constants of the mailbox syntax checker
// no dependencies
package eavc_pkg;

	localparam int COMMENT_DEPTH_BITS = 4;
	localparam int QUEUE_DEPTH        = 2;
	localparam int STATUS_W           = 4;

	typedef enum logic [3:0] {
		CC_OTHER,
		CC_BSLASH,
		CC_DQUOTE,
		CC_LPAREN,
		CC_RPAREN,
		CC_BRACKET,
		CC_COLON,
		CC_LANGLE,
		CC_RANGLE,
		CC_SEP,
		CC_AT
	} char_class_t;

	typedef enum logic [1:0] {
		CTX_TOP,
		CTX_COMMENT,
		CTX_ANGLE
	} ctx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_EMPTY,
		ST_NO_AT,
		ST_MANY_AT,
		ST_NO_LOCAL,
		ST_NO_DOMAIN,
		ST_PARENS,
		ST_UNCLOSED_ANGLE,
		ST_UNOPENED_ANGLE,
		ST_COMMA,
		ST_END,
		ST_QUOTE,
		ST_BAD_CHAR,
		ST_BAD_NAME,
		ST_TOO_DEEP
	} status_t;

	// one classified word as it sits in the queue
	typedef struct packed {
		char_class_t cls;
		logic        no_char;
		logic        last;
	} item_t;

endpackage

[sv/eavc_addr_if.sv]
// input channel: at most one byte of the address string per word
// depends on nothing
interface eavc_addr_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       no_char;
	logic       last;

	modport source (output valid, ch, no_char, last, input ready);
	modport sink (input valid, ch, no_char, last, output ready);
endinterface

[sv/eavc_result_if.sv]
// output channel: one status code per address string
// depends on eavc_pkg for the status width
interface eavc_result_if;
	logic                          valid;
	logic                          ready;
	logic [eavc_pkg::STATUS_W-1:0] status;

	modport source (output valid, status, input ready);
	modport sink (input valid, status, output ready);
endinterface

[sv/email_address_validator_core.sv]
// top level of the streaming mailbox syntax checker
// depends on eavc_pkg, eavc_addr_if, eavc_result_if, eavc_front and eavc_back
//
// channel  dir  fields               word
// addr     in   ch, no_char, last    one byte of the address string
// result   out  status               one code after the word marked last
//
// one word per cycle sustained while each status is taken; an accepted word is queued and parsed at the queue head
// the status is valid from the edge that parses the last word
// a status not yet taken holds the next last word at the queue head
// the two-entry queue then fills and addr.ready drops until the status is taken
// reset clears the queue, parser state and result valid at once, no clearing pass
module email_address_validator_core #(
	parameter int COMMENT_DEPTH_BITS = eavc_pkg::COMMENT_DEPTH_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	eavc_addr_if.sink     addr,
	eavc_result_if.source result
);

	logic            q_valid;
	logic            q_pop;
	eavc_pkg::item_t q_item;

	eavc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.addr    (addr),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	eavc_back #(
		.COMMENT_DEPTH_BITS (COMMENT_DEPTH_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

[sv/eavc_front.sv]
// front end: accepts input words, classifies the byte, queues the word
// depends on eavc_pkg, eavc_addr_if and the assertion header
`include "email_address_validator_core_assert.svh"

module eavc_front (
	input  logic            clk,
	input  logic            arst_n,
	eavc_addr_if.sink       addr,
	output logic            q_valid,
	output eavc_pkg::item_t q_item,
	input  logic            q_pop
);

	localparam int PTR_W = (eavc_pkg::QUEUE_DEPTH > 1) ? $clog2(eavc_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(eavc_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(eavc_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(eavc_pkg::QUEUE_DEPTH);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LANGLE = 8'h3C;
	localparam logic [7:0] CH_RANGLE = 8'h3E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AT     = 8'h40;

	eavc_pkg::item_t  mem_q [eavc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;
	eavc_pkg::item_t  new_item;

	always_comb begin
		new_item.no_char = addr.no_char;
		new_item.last    = addr.last;
		case (addr.ch)
			CH_BSLASH: new_item.cls = eavc_pkg::CC_BSLASH;
			CH_DQUOTE: new_item.cls = eavc_pkg::CC_DQUOTE;
			CH_LPAREN: new_item.cls = eavc_pkg::CC_LPAREN;
			CH_RPAREN: new_item.cls = eavc_pkg::CC_RPAREN;
			CH_LBRACK: new_item.cls = eavc_pkg::CC_BRACKET;
			CH_RBRACK: new_item.cls = eavc_pkg::CC_BRACKET;
			CH_COLON:  new_item.cls = eavc_pkg::CC_COLON;
			CH_LANGLE: new_item.cls = eavc_pkg::CC_LANGLE;
			CH_RANGLE: new_item.cls = eavc_pkg::CC_RANGLE;
			CH_COMMA:  new_item.cls = eavc_pkg::CC_SEP;
			CH_SEMI:   new_item.cls = eavc_pkg::CC_SEP;
			CH_AT:     new_item.cls = eavc_pkg::CC_AT;
			default:   new_item.cls = eavc_pkg::CC_OTHER;
		endcase
	end

	assign addr.ready = (count_q != CNT_FULL);
	assign push       = addr.valid && addr.ready;
	assign q_valid    = (count_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_item     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`EAVC_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_FULL, "queue count beyond depth")
	`EAVC_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 1'b1, "push lost")
	`EAVC_ASSERT_IMPL(a_ptr_gap, count_q == '0, wr_q == rd_q, "empty queue with pointer gap")

endmodule

[sv/eavc_back.sv]
// back end: parses classified words and holds the status result register
// depends on eavc_pkg, eavc_result_if and the assertion header
`include "email_address_validator_core_assert.svh"

module eavc_back #(
	parameter int COMMENT_DEPTH_BITS = eavc_pkg::COMMENT_DEPTH_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  eavc_pkg::item_t q_item,
	output logic            q_pop,
	eavc_result_if.source   result
);

	localparam logic [COMMENT_DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam logic [COMMENT_DEPTH_BITS-1:0] DEPTH_ONE = COMMENT_DEPTH_BITS'(1);

	eavc_pkg::ctx_t                ctx_q, ctx_d;
	logic                          quote_q, quote_d;
	logic                          skip_q, skip_d;
	logic [COMMENT_DEPTH_BITS-1:0] depth_q, depth_d;
	eavc_pkg::status_t             err_q, err_d;
	logic                          any_at_q, any_at_d;
	logic [1:0]                    at_cnt_q, at_cnt_d;
	logic                          first_q, first_d;
	logic                          res_valid_q;
	eavc_pkg::status_t             status_q;
	eavc_pkg::status_t             resolved;
	logic                          is_at;
	logic                          quoted_at;
	logic                          done;

	// words without last never wait on the result register
	assign q_pop = q_valid && (!q_item.last || !res_valid_q || result.ready);
	assign done  = q_pop && q_item.last;

	always_comb begin
		ctx_d     = ctx_q;
		quote_d   = quote_q;
		skip_d    = skip_q;
		depth_d   = depth_q;
		err_d     = err_q;
		any_at_d  = any_at_q;
		at_cnt_d  = at_cnt_q;
		first_d   = first_q;
		is_at     = (q_item.cls == eavc_pkg::CC_AT);
		quoted_at = 1'b0;
		if (q_pop && !q_item.no_char) begin
			if (is_at) begin
				any_at_d = 1'b1;
			end
			// after the first error bytes are only scanned for '@'
			if (err_q == eavc_pkg::ST_OK) begin
				if (skip_q) begin
					skip_d = 1'b0;
				end else if (q_item.cls == eavc_pkg::CC_BSLASH) begin
					if (q_item.last) begin
						err_d = eavc_pkg::ST_END;
					end else begin
						skip_d = 1'b1;
					end
				end else begin
					case (ctx_q)
						eavc_pkg::CTX_COMMENT: begin
							if (q_item.cls == eavc_pkg::CC_LPAREN) begin
								if (depth_q == DEPTH_MAX) begin
									err_d = eavc_pkg::ST_TOO_DEEP;
								end else begin
									depth_d = depth_q + 1'b1;
								end
							end else if (q_item.cls == eavc_pkg::CC_RPAREN) begin
								depth_d = depth_q - 1'b1;
								if (depth_d == '0) begin
									ctx_d = eavc_pkg::CTX_TOP;
								end
							end
						end
						eavc_pkg::CTX_ANGLE: begin
							if (q_item.cls == eavc_pkg::CC_DQUOTE) begin
								quote_d = !quote_q;
							end else if (!quote_q) begin
								if (q_item.cls == eavc_pkg::CC_SEP) begin
									err_d = eavc_pkg::ST_COMMA;
								end else if (q_item.cls == eavc_pkg::CC_RANGLE) begin
									ctx_d = eavc_pkg::CTX_TOP;
								end
							end else begin
								quoted_at = is_at;
							end
						end
						default: begin
							if (q_item.cls == eavc_pkg::CC_DQUOTE) begin
								quote_d = !quote_q;
							end else if (quote_q) begin
								quoted_at = is_at;
							end else begin
								case (q_item.cls)
									eavc_pkg::CC_LPAREN: begin
										ctx_d   = eavc_pkg::CTX_COMMENT;
										depth_d = DEPTH_ONE;
									end
									eavc_pkg::CC_BRACKET: err_d = eavc_pkg::ST_BAD_NAME;
									eavc_pkg::CC_COLON:   err_d = eavc_pkg::ST_BAD_CHAR;
									eavc_pkg::CC_LANGLE:  ctx_d = eavc_pkg::CTX_ANGLE;
									eavc_pkg::CC_SEP:     err_d = eavc_pkg::ST_COMMA;
									eavc_pkg::CC_RPAREN:  err_d = eavc_pkg::ST_PARENS;
									eavc_pkg::CC_RANGLE:  err_d = eavc_pkg::ST_UNOPENED_ANGLE;
									eavc_pkg::CC_AT: begin
										if (first_q) begin
											err_d = eavc_pkg::ST_NO_LOCAL;
										end else if (q_item.last) begin
											err_d = eavc_pkg::ST_NO_DOMAIN;
										end
									end
									default: ;
								endcase
							end
						end
					endcase
				end
			end
			if (is_at && !quoted_at && at_cnt_q != 2'd2) begin
				at_cnt_d = at_cnt_q + 1'b1;
			end
			first_d = 1'b0;
		end

		// outcome precedence
		if (first_d) begin
			resolved = eavc_pkg::ST_EMPTY;
		end else if (!any_at_d) begin
			resolved = eavc_pkg::ST_NO_AT;
		end else if (err_d != eavc_pkg::ST_OK) begin
			resolved = err_d;
		end else if (skip_d) begin
			resolved = eavc_pkg::ST_END;
		end else if (at_cnt_d == 2'd0 && !quote_d) begin
			resolved = eavc_pkg::ST_NO_AT;
		end else if (quote_d) begin
			resolved = eavc_pkg::ST_QUOTE;
		end else if (ctx_d == eavc_pkg::CTX_COMMENT) begin
			resolved = eavc_pkg::ST_PARENS;
		end else if (ctx_d == eavc_pkg::CTX_ANGLE) begin
			resolved = eavc_pkg::ST_UNCLOSED_ANGLE;
		end else if (at_cnt_d == 2'd2) begin
			resolved = eavc_pkg::ST_MANY_AT;
		end else begin
			resolved = eavc_pkg::ST_OK;
		end

		// string done: back to the reset state for the next one
		if (done) begin
			ctx_d    = eavc_pkg::CTX_TOP;
			quote_d  = 1'b0;
			skip_d   = 1'b0;
			depth_d  = '0;
			err_d    = eavc_pkg::ST_OK;
			any_at_d = 1'b0;
			at_cnt_d = 2'd0;
			first_d  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q       <= eavc_pkg::CTX_TOP;
			quote_q     <= 1'b0;
			skip_q      <= 1'b0;
			depth_q     <= '0;
			err_q       <= eavc_pkg::ST_OK;
			any_at_q    <= 1'b0;
			at_cnt_q    <= 2'd0;
			first_q     <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			ctx_q    <= ctx_d;
			quote_q  <= quote_d;
			skip_q   <= skip_d;
			depth_q  <= depth_d;
			err_q    <= err_d;
			any_at_q <= any_at_d;
			at_cnt_q <= at_cnt_d;
			first_q  <= first_d;
			if (done) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= resolved;
		end
	end

	assign result.valid  = res_valid_q;
	assign result.status = status_q;

	`EAVC_ASSERT_ALWAYS(a_at_cnt_sat, at_cnt_q != 2'd3, "at count passed saturation")
	`EAVC_ASSERT_IMPL(a_comment_depth, ctx_q == eavc_pkg::CTX_COMMENT, depth_q != '0, "comment with zero depth")
	`EAVC_ASSERT_NEXT(a_clear_after_last, done, first_q && err_q == eavc_pkg::ST_OK && res_valid_q, "string end not cleared")

endmodule

[tb/email_address_validator_core_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for email_address_validator_core: streams address strings and
// checks each status word against a cycle-free model of the parser kept in a class
// depends on eavc_pkg, eavc_addr_if, eavc_result_if and the core itself
module email_address_validator_core_tb;

	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_WORDS = 400;
	localparam int HOLD_CYCLES  = 80;
	localparam int DEPTH_W      = eavc_pkg::COMMENT_DEPTH_BITS;

	localparam logic [7:0] CH_AT     = "@";
	localparam logic [7:0] CH_BSLASH = "\\";
	localparam logic [7:0] CH_DQUOTE = "\"";
	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_LBRACK = "[";
	localparam logic [7:0] CH_RBRACK = "]";
	localparam logic [7:0] CH_COLON  = ":";
	localparam logic [7:0] CH_LANGLE = "<";
	localparam logic [7:0] CH_RANGLE = ">";
	localparam logic [7:0] CH_COMMA  = ",";
	localparam logic [7:0] CH_SEMI   = ";";
	localparam logic [7:0] CH_SPACE  = " ";

	localparam string PLAIN_SET   = "abcdefghijklmnopqrstuvwxyz0123456789.-_";
	localparam string SPECIAL_SET = "\"\\()[]:<>,;@";

	// kinds of filler text
	localparam int TXT_PLAIN = 0;
	localparam int TXT_MIXED = 1;
	localparam int TXT_ANY   = 2;

	// shapes of generated addresses
	localparam int SH_PLAIN   = 0;
	localparam int SH_QUOTED  = 1;
	localparam int SH_NAMED   = 2;
	localparam int SH_COMMENT = 3;
	localparam int SH_ESCAPE  = 4;

	class mailbox_scoreboard;
		eavc_pkg::ctx_t    ctx;
		bit                in_quote;
		bit                skip_next;
		logic [DEPTH_W-1:0] depth;
		eavc_pkg::status_t first_err;
		bit                any_at;
		bit [1:0]          at_cnt;
		bit                at_start;
		eavc_pkg::status_t expected_status[$];
		int unsigned       errors;
		int unsigned       checked;
		bit [15:0]         codes_hit;

		function new();
			errors = 0;
			checked = 0;
			codes_hit = '0;
			clear();
		endfunction

		function void clear();
			ctx = eavc_pkg::CTX_TOP;
			in_quote = 1'b0;
			skip_next = 1'b0;
			depth = '0;
			first_err = eavc_pkg::ST_OK;
			any_at = 1'b0;
			at_cnt = 2'd0;
			at_start = 1'b1;
		endfunction

		function void latch_err(eavc_pkg::status_t code);
			if (first_err == eavc_pkg::ST_OK) begin
				first_err = code;
			end
		endfunction

		// update the parser state with one accepted word
		function void note_word(logic [7:0] c, logic nc, logic lst);
			bit                quoted_at;
			eavc_pkg::status_t st;
			quoted_at = 0;
			if (!nc) begin
				if (c == CH_AT) begin
					any_at = 1;
				end
				// after the first error bytes are only scanned for '@'
				if (first_err == eavc_pkg::ST_OK) begin
					if (skip_next) begin
						skip_next = 0;
					end else if (c == CH_BSLASH) begin
						if (lst) begin
							latch_err(eavc_pkg::ST_END);
						end else begin
							skip_next = 1;
						end
					end else if (ctx == eavc_pkg::CTX_COMMENT) begin
						if (c == CH_LPAREN) begin
							if (depth == '1) begin
								latch_err(eavc_pkg::ST_TOO_DEEP);
							end else begin
								depth++;
							end
						end else if (c == CH_RPAREN) begin
							depth--;
							if (depth == '0) begin
								ctx = eavc_pkg::CTX_TOP;
							end
						end
					end else if (ctx == eavc_pkg::CTX_ANGLE) begin
						if (c == CH_DQUOTE) begin
							in_quote = !in_quote;
						end else if (!in_quote) begin
							if (c == CH_COMMA || c == CH_SEMI) begin
								latch_err(eavc_pkg::ST_COMMA);
							end else if (c == CH_RANGLE) begin
								ctx = eavc_pkg::CTX_TOP;
							end
						end else begin
							quoted_at = (c == CH_AT);
						end
					end else if (c == CH_DQUOTE) begin
						in_quote = !in_quote;
					end else if (in_quote) begin
						quoted_at = (c == CH_AT);
					end else begin
						case (c)
							CH_LPAREN: begin
								ctx = eavc_pkg::CTX_COMMENT;
								depth = DEPTH_W'(1);
							end
							CH_LBRACK, CH_RBRACK: latch_err(eavc_pkg::ST_BAD_NAME);
							CH_COLON: latch_err(eavc_pkg::ST_BAD_CHAR);
							CH_LANGLE: ctx = eavc_pkg::CTX_ANGLE;
							CH_COMMA, CH_SEMI: latch_err(eavc_pkg::ST_COMMA);
							CH_RPAREN: latch_err(eavc_pkg::ST_PARENS);
							CH_RANGLE: latch_err(eavc_pkg::ST_UNOPENED_ANGLE);
							CH_AT: begin
								if (at_start) begin
									latch_err(eavc_pkg::ST_NO_LOCAL);
								end else if (lst) begin
									latch_err(eavc_pkg::ST_NO_DOMAIN);
								end
							end
							default: ;
						endcase
					end
				end
				if (c == CH_AT && !quoted_at && at_cnt < 2) begin
					at_cnt++;
				end
				at_start = 0;
			end
			if (lst) begin
				if (at_start) begin
					st = eavc_pkg::ST_EMPTY;
				end else if (!any_at) begin
					st = eavc_pkg::ST_NO_AT;
				end else if (first_err != eavc_pkg::ST_OK) begin
					st = first_err;
				end else if (skip_next) begin
					st = eavc_pkg::ST_END;
				end else if (at_cnt == 0 && !in_quote) begin
					st = eavc_pkg::ST_NO_AT;
				end else if (in_quote) begin
					st = eavc_pkg::ST_QUOTE;
				end else if (ctx == eavc_pkg::CTX_COMMENT) begin
					st = eavc_pkg::ST_PARENS;
				end else if (ctx == eavc_pkg::CTX_ANGLE) begin
					st = eavc_pkg::ST_UNCLOSED_ANGLE;
				end else if (at_cnt >= 2) begin
					st = eavc_pkg::ST_MANY_AT;
				end else begin
					st = eavc_pkg::ST_OK;
				end
				expected_status.push_back(st);
				codes_hit[st] = 1'b1;
				clear();
			end
		endfunction

		function void check_status(logic [eavc_pkg::STATUS_W-1:0] got);
			eavc_pkg::status_t want;
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t: status %0d arrived with no string pending", $time, got);
				return;
			end
			want = expected_status.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				$display("%0t: status mismatch: expected %0d (%s), got %0d",
					$time, want, want.name(), got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	eavc_addr_if   addr_ch();
	eavc_result_if res_ch();

	email_address_validator_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (addr_ch),
		.result (res_ch)
	);

	mailbox_scoreboard sb;
	bit                steady;
	bit                hold_go;
	bit                hold;
	int unsigned       strings_sent;
	int unsigned       random_words;
	bit                in_random;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// observe both channels at the edge, before anything is updated
	always @(posedge clk) begin
		if (arst_n) begin
			if (addr_ch.valid && addr_ch.ready) begin
				sb.note_word(addr_ch.ch, addr_ch.no_char, addr_ch.last);
			end
			if (res_ch.valid && res_ch.ready) begin
				sb.check_status(res_ch.status);
			end
		end
	end

	always @(posedge clk) begin
		res_ch.ready <= !hold && (steady || $urandom_range(0, 99) >= 9);
	end

	// one long hold-off on the result side so the core backs up
	initial begin
		hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold <= 1'b0;
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((addr_ch.valid && addr_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
		$display("** email_address_validator_core: FAILED **");
		$finish;
	end

	function automatic logic [7:0] rand_from(string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic void add_text(ref logic [7:0] q[$], input int n, input int kind);
		for (int i = 0; i < n; i++) begin
			case (kind)
				TXT_PLAIN: q.push_back(rand_from(PLAIN_SET));
				TXT_MIXED: q.push_back(($urandom_range(0, 3) == 0) ?
					rand_from(SPECIAL_SET) : rand_from(PLAIN_SET));
				default: q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	task automatic put_word(input logic [7:0] c, input logic nc, input logic lst);
		while (!steady && $urandom_range(0, 99) < 9) begin
			addr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		addr_ch.valid   <= 1'b1;
		addr_ch.ch      <= c;
		addr_ch.no_char <= nc;
		addr_ch.last    <= lst;
		@(posedge clk);
		while (!addr_ch.ready) @(posedge clk);
		if (in_random && !(nc && !lst)) begin
			random_words++;
		end
	endtask

	// a string ends either on its final byte or on a separate empty word
	task automatic send_addr(input logic [7:0] q[$], input bit nochar_end);
		for (int i = 0; i < q.size(); i++) begin
			if ($urandom_range(0, 99) < 4) begin
				put_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			end
			put_word(q[i], 1'b0, !nochar_end && i == q.size() - 1);
		end
		if (nochar_end || q.size() == 0) begin
			put_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
		strings_sent++;
	endtask

	task automatic send_text(input string s, input bit nochar_end);
		logic [7:0] q[$];
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
		send_addr(q, nochar_end);
	endtask

	initial begin
		logic [7:0] word_q[$];
		int         pick;
		int         shape;
		int         n;
		bit         nochar_end;

		sb = new();
		steady = 1'b0;
		hold_go = 1'b0;
		in_random = 1'b0;
		strings_sent = 0;
		random_words = 0;
		arst_n = 1'b0;
		addr_ch.valid = 1'b0;
		addr_ch.ch = 8'h00;
		addr_ch.no_char = 1'b0;
		addr_ch.last = 1'b0;
		res_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings: every status code and the edge cases
		send_text("", 1'b1);
		send_text("a@b", 1'b0);
		put_word(8'hA5, 1'b1, 1'b0);
		send_text("a@b", 1'b1);
		send_text("ab", 1'b0);
		send_text("a@b@c", 1'b0);
		send_text("@b", 1'b0);
		send_text("a@", 1'b0);
		send_text("a@", 1'b1);
		send_text("(a@b", 1'b0);
		send_text("a(b(c)d)e@f", 1'b0);
		send_text("a@b)", 1'b0);
		send_text("<a@b", 1'b0);
		send_text("x <\"a@\"b@c>", 1'b0);
		send_text("a@b>", 1'b0);
		send_text("a,@b;", 1'b0);
		send_text("a@b\\", 1'b0);
		send_text("a@\\", 1'b1);
		send_text("a\\@@b", 1'b0);
		send_text("\"a@b", 1'b0);
		send_text("\"a@b\"", 1'b0);
		send_text("a:@b", 1'b0);
		send_text("a@[b]", 1'b0);
		send_text("(((((((((((((((a)))))))))))))))@b", 1'b0);
		send_text("((((((((((((((((a)@b", 1'b0);
		word_q = '{8'h00, CH_AT, 8'hFF};
		send_addr(word_q, 1'b0);

		// random strings, mostly address-shaped with random content
		in_random = 1'b1;
		while (random_words < RANDOM_WORDS) begin
			if (strings_sent == 40) begin
				hold_go = 1'b1;
			end
			steady = (strings_sent >= 60 && strings_sent < 80);
			word_q.delete();
			nochar_end = ($urandom_range(0, 99) < 15);
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				nochar_end = 1'b1;
			end else if (pick < 64) begin
				shape = $urandom_range(SH_PLAIN, SH_ESCAPE);
				case (shape)
					SH_PLAIN: begin
						add_text(word_q, $urandom_range(1, 4), TXT_PLAIN);
						word_q.push_back(CH_AT);
						add_text(word_q, $urandom_range(1, 4), TXT_PLAIN);
					end
					SH_QUOTED: begin
						word_q.push_back(CH_DQUOTE);
						add_text(word_q, $urandom_range(0, 3), TXT_MIXED);
						if ($urandom_range(0, 1)) begin
							word_q.push_back(CH_AT);
						end
						word_q.push_back(CH_DQUOTE);
						word_q.push_back(CH_AT);
						add_text(word_q, $urandom_range(1, 3), TXT_PLAIN);
					end
					SH_NAMED: begin
						add_text(word_q, $urandom_range(1, 3), TXT_PLAIN);
						word_q.push_back(CH_SPACE);
						word_q.push_back(CH_LANGLE);
						add_text(word_q, $urandom_range(0, 3), TXT_MIXED);
						word_q.push_back(CH_AT);
						add_text(word_q, $urandom_range(1, 3), TXT_PLAIN);
						word_q.push_back(CH_RANGLE);
					end
					SH_COMMENT: begin
						word_q.push_back(CH_LPAREN);
						add_text(word_q, $urandom_range(0, 3), TXT_MIXED);
						word_q.push_back(CH_RPAREN);
						add_text(word_q, $urandom_range(1, 3), TXT_PLAIN);
						word_q.push_back(CH_AT);
						add_text(word_q, $urandom_range(1, 3), TXT_PLAIN);
					end
					default: begin
						add_text(word_q, $urandom_range(0, 2), TXT_PLAIN);
						word_q.push_back(CH_BSLASH);
						add_text(word_q, 1, TXT_ANY);
						add_text(word_q, $urandom_range(0, 2), TXT_PLAIN);
						word_q.push_back(CH_AT);
						add_text(word_q, $urandom_range(1, 3), TXT_PLAIN);
					end
				endcase
				// break some of them at one spot
				if ($urandom_range(0, 3) == 0) begin
					n = $urandom_range(0, word_q.size() - 1);
					word_q[n] = $urandom_range(0, 1) ? rand_from(SPECIAL_SET) :
						8'($urandom_range(0, 255));
				end
			end else if (pick < 70) begin
				// comment nesting around the counter limit
				n = $urandom_range(13, 17);
				repeat (n) word_q.push_back(CH_LPAREN);
				add_text(word_q, $urandom_range(0, 2), TXT_MIXED);
				repeat ($urandom_range(0, n)) word_q.push_back(CH_RPAREN);
				word_q.push_back(CH_AT);
				add_text(word_q, $urandom_range(1, 2), TXT_PLAIN);
			end else begin
				add_text(word_q, $urandom_range(1, 10),
					$urandom_range(0, 1) ? TXT_MIXED : TXT_ANY);
			end
			send_addr(word_q, nochar_end);
		end
		steady = 1'b0;
		addr_ch.valid <= 1'b0;

		while (sb.expected_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d address strings sent (%0d random words), %0d status words checked",
			strings_sent, random_words, sb.checked);
		$display("status codes reached: %b (bit n set for code n)", sb.codes_hit);
		if (sb.errors == 0) begin
			$display("** email_address_validator_core: PASSED **");
		end else begin
			$display("** email_address_validator_core: FAILED **");
		end
		$finish;
	end

endmodule
